[hdl/tfs_pkg.sv]
`default_nettype none

package tfs_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int TAG_BITS    = 8;

    localparam int ADDR_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int COUNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int MODE_W    = 3;
    localparam int WORD_W    = 64;
    localparam int PAYLOAD_W = 56;
    localparam int TAG_W     = 8;
    localparam int DEPTH_W   = 11;
    localparam int STATUS_W  = 3;
    localparam int LEVEL_W   = 11;
    localparam int CMP_W     = (COUNT_W > DEPTH_W) ? COUNT_W : DEPTH_W;

    localparam logic [WORD_W-1:0] TAG_MASK = (WORD_W'(1) << TAG_BITS) - WORD_W'(1);

    localparam logic [MODE_W-1:0] MODE_PUSH_RAW    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_TAGGED = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP         = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PEEK        = 3'd3;
    localparam logic [MODE_W-1:0] MODE_UNWIND      = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_DEPTH = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic load;
        logic exec;
    } tfs_cmd_t;

    typedef struct packed {
        logic finish;
    } tfs_sts_t;

endpackage

`default_nettype wire

[hdl/tagged_frame_stack.sv]
// Tagged frame stack: bounded stack of 64-bit frames with tag-based unwind.
// Request channel: present mode and operands with start; a beat is taken at
// a clock edge where start is high and busy is low. busy stays high while
// the request executes.
// Result channel: done is high for exactly one cycle with word_out,
// payload_out, tag_out, status and level. The receiver cannot stall; the
// result must be captured in that cycle. Results stay on the ports until
// the next done, and busy is already low in the done cycle.
// Push, pop and peek finish after a single execute state: pop and peek read
// from an address issued in the accept cycle, push writes in the execute
// state unless the stack is full. Unwind stays in the execute state until
// the tag matches or the stack is exhausted; the single memory port reads
// one frame a cycle. No new request is taken while one is executing.
// Reset (rst_n low, asynchronous) empties the stack and returns to idle;
// stored frames are not cleared, and no frame is used before it is written.
`default_nettype none

module tagged_frame_stack
    import tfs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [MODE_W-1:0]           mode,
    input  logic [WORD_W-1:0]           frame_word,
    input  logic signed [PAYLOAD_W-1:0] payload,
    input  logic [TAG_W-1:0]            tag,
    input  logic [DEPTH_W-1:0]          peek_depth,
    output logic                        done,
    output logic [WORD_W-1:0]           word_out,
    output logic signed [PAYLOAD_W-1:0] payload_out,
    output logic [TAG_W-1:0]            tag_out,
    output logic [STATUS_W-1:0]         status,
    output logic [LEVEL_W-1:0]          level
);

    tfs_cmd_t cmd;
    tfs_sts_t sts;

    tfs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    tfs_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode        (mode),
        .frame_word  (frame_word),
        .payload     (payload),
        .tag         (tag),
        .peek_depth  (peek_depth),
        .sts         (sts),
        .word_out    (word_out),
        .payload_out (payload_out),
        .tag_out     (tag_out),
        .status      (status),
        .level       (level)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_err_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != STATUS_OK) |-> (word_out == '0) && (tag_out == '0))
        else $error("frame data on an error beat");

    a_not_found_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == STATUS_NOT_FOUND) |-> (level == '0))
        else $error("failed unwind left frames on the stack");
`endif

endmodule

`default_nettype wire

[hdl/tfs_ram.sv]
`default_nettype none

module tfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[hdl/tfs_ctrl.sv]
`default_nettype none

module tfs_ctrl
    import tfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  tfs_sts_t sts,
    output tfs_cmd_t cmd,
    output logic     busy,
    output logic     done
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.finish)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

[hdl/tfs_datapath.sv]
`default_nettype none

module tfs_datapath
    import tfs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tfs_cmd_t                    cmd,
    input  logic [MODE_W-1:0]           mode,
    input  logic [WORD_W-1:0]           frame_word,
    input  logic signed [PAYLOAD_W-1:0] payload,
    input  logic [TAG_W-1:0]            tag,
    input  logic [DEPTH_W-1:0]          peek_depth,
    output tfs_sts_t                    sts,
    output logic [WORD_W-1:0]           word_out,
    output logic signed [PAYLOAD_W-1:0] payload_out,
    output logic [TAG_W-1:0]            tag_out,
    output logic [STATUS_W-1:0]         status,
    output logic [LEVEL_W-1:0]          level
);

    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   ptr_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [WORD_W-1:0]    wr_word_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [DEPTH_W-1:0]   depth_reg;

    logic [WORD_W-1:0]    word_out_reg;
    logic [PAYLOAD_W-1:0] payload_out_reg;
    logic [TAG_W-1:0]     tag_out_reg;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [LEVEL_W-1:0]   level_reg;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [WORD_W-1:0]    ram_rdata;
    logic [WORD_W-1:0]    tagged_word;
    logic [WORD_W-1:0]    frame;
    logic signed [WORD_W-1:0] frame_shr;

    logic is_push, full, peek_bad, match, finish, frame_sel;

    tfs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wr_word_reg),
        .rdata (ram_rdata)
    );

    assign tagged_word = (WORD_W'(payload) << TAG_BITS) | (WORD_W'(tag) & TAG_MASK);

    assign is_push  = (mode_reg == MODE_PUSH_RAW) || (mode_reg == MODE_PUSH_TAGGED);
    assign full     = (count_reg >= COUNT_W'(STACK_DEPTH));
    assign peek_bad = (depth_reg == '0) || (CMP_W'(depth_reg) > CMP_W'(count_reg));
    assign match    = ((ram_rdata & TAG_MASK) == WORD_W'(tag_reg));

    // Read address: from the request while idle, so data is ready in the first
    // execute cycle; during unwind the next frame down is prefetched.
    always_comb
    begin
        ram_we   = 1'b0;
        ram_addr = ADDR_W'(count_reg - COUNT_W'(1));
        if (cmd.exec)
        begin
            if (is_push)
            begin
                ram_addr = ADDR_W'(count_reg);
                ram_we   = !full;
            end
            else
            begin
                ram_addr = ADDR_W'(ptr_reg - COUNT_W'(2));
            end
        end
        else if (mode == MODE_PEEK)
        begin
            ram_addr = ADDR_W'(CMP_W'(count_reg) - CMP_W'(peek_depth));
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = STATUS_OK;
        finish      = 1'b1;
        frame_sel   = 1'b0;
        case (mode_reg)
            MODE_PUSH_RAW, MODE_PUSH_TAGGED:
            begin
                if (full)
                begin
                    status_next = STATUS_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            MODE_POP:
            begin
                if (count_reg == '0)
                begin
                    status_next = STATUS_UNDERFLOW;
                end
                else
                begin
                    count_next = count_reg - COUNT_W'(1);
                    frame_sel  = 1'b1;
                end
            end
            MODE_PEEK:
            begin
                if (peek_bad)
                begin
                    status_next = STATUS_BAD_DEPTH;
                end
                else
                begin
                    frame_sel = 1'b1;
                end
            end
            MODE_UNWIND:
            begin
                if (ptr_reg == '0)
                begin
                    count_next  = '0;
                    status_next = STATUS_NOT_FOUND;
                end
                else if (match)
                begin
                    count_next = ptr_reg;
                end
                else
                begin
                    finish = 1'b0;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign frame     = frame_sel ? ram_rdata : '0;
    assign frame_shr = $signed(frame) >>> TAG_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec && finish)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= mode;
            wr_word_reg <= (mode == MODE_PUSH_TAGGED) ? tagged_word : frame_word;
            tag_reg     <= tag;
            depth_reg   <= peek_depth;
            ptr_reg     <= count_reg;
        end
        else if (cmd.exec && !finish)
        begin
            ptr_reg <= ptr_reg - COUNT_W'(1);
        end

        if (cmd.exec && finish)
        begin
            word_out_reg    <= frame;
            payload_out_reg <= frame_shr[PAYLOAD_W-1:0];
            tag_out_reg     <= frame[TAG_W-1:0] & TAG_MASK[TAG_W-1:0];
            status_reg      <= status_next;
            level_reg       <= LEVEL_W'(count_next);
        end
    end

    assign sts.finish  = finish;
    assign word_out    = word_out_reg;
    assign payload_out = payload_out_reg;
    assign tag_out     = tag_out_reg;
    assign status      = status_reg;
    assign level       = level_reg;

endmodule

`default_nettype wire

[tb/tagged_frame_stack_tb.sv]
`default_nettype none

module tagged_frame_stack_tb;
    import tfs_pkg::*;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [WORD_W-1:0]    word;
        logic [PAYLOAD_W-1:0] payload;
        logic [TAG_W-1:0]     tag;
        logic [DEPTH_W-1:0]   depth;
    } stack_req_t;

    typedef struct packed {
        logic [WORD_W-1:0]    word;
        logic [PAYLOAD_W-1:0] payload;
        logic [TAG_W-1:0]     tag;
        logic [STATUS_W-1:0]  status;
        logic [LEVEL_W-1:0]   level;
    } stack_rsp_t;

    typedef struct packed {
        stack_req_t req;
        logic       fixed;
        stack_rsp_t rsp;
    } stim_row_t;

    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int RAND_ITEMS  = 750;
    localparam int PHASE_LEN   = 150;

    localparam logic [MODE_W-1:0] MODE_RSVD_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD_7 = 3'd7;

    localparam logic [PAYLOAD_W-1:0] PAY_MAX = {1'b0, {(PAYLOAD_W-1){1'b1}}};
    localparam logic [PAYLOAD_W-1:0] PAY_MIN = {1'b1, {(PAYLOAD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0]    WORD_ONES = {WORD_W{1'b1}};
    localparam logic [TAG_W-1:0]     BASE_TAG = 8'hEF;
    localparam logic [TAG_W-1:0]     MISS_TAG = 8'hEE;
    localparam logic [LEVEL_W-1:0]   FULL_LEVEL = LEVEL_W'(STACK_DEPTH);

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [MODE_W-1:0]    mode;
    logic [WORD_W-1:0]    frame_word;
    logic [PAYLOAD_W-1:0] payload;
    logic [TAG_W-1:0]     tag;
    logic [DEPTH_W-1:0]   peek_depth;
    logic                 done;
    logic [WORD_W-1:0]    word_out;
    logic [PAYLOAD_W-1:0] payload_out;
    logic [TAG_W-1:0]     tag_out;
    logic [STATUS_W-1:0]  status;
    logic [LEVEL_W-1:0]   level;

    logic [WORD_W-1:0] stk_frames [STACK_DEPTH];
    int                stk_level = 0;
    stack_rsp_t        pending_rsp [$];
    stim_row_t         stim_rows [$];
    int                err_count = 0;
    int                cyc_count = 0;
    int                quiet_left = 0;

    tagged_frame_stack u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .frame_word  (frame_word),
        .payload     (payload),
        .tag         (tag),
        .peek_depth  (peek_depth),
        .done        (done),
        .word_out    (word_out),
        .payload_out (payload_out),
        .tag_out     (tag_out),
        .status      (status),
        .level       (level)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cyc_count <= cyc_count + 1;
        if (cyc_count >= CYCLE_LIMIT)
        begin
            $display("FAIL tagged_frame_stack");
            $finish;
        end
    end

    function automatic stack_rsp_t stack_predict(stack_req_t rq);
        stack_rsp_t        rs;
        logic [WORD_W-1:0] w;
        logic              rd;
        logic              hit;
        int                i;
        rs = '0;
        w = '0;
        rd = 1'b0;
        hit = 1'b0;
        case (rq.mode)
            MODE_PUSH_RAW, MODE_PUSH_TAGGED:
            begin
                if (stk_level >= STACK_DEPTH)
                    rs.status = STATUS_OVERFLOW;
                else
                begin
                    w = rq.word;
                    if (rq.mode == MODE_PUSH_TAGGED)
                        w = (WORD_W'($signed(rq.payload)) << TAG_BITS)
                            | (WORD_W'(rq.tag) & TAG_MASK);
                    stk_frames[stk_level] = w;
                    stk_level++;
                end
            end
            MODE_POP:
            begin
                if (stk_level == 0)
                    rs.status = STATUS_UNDERFLOW;
                else
                begin
                    stk_level--;
                    w = stk_frames[stk_level];
                    rd = 1'b1;
                end
            end
            MODE_PEEK:
            begin
                if (rq.depth == '0 || int'(rq.depth) > stk_level)
                    rs.status = STATUS_BAD_DEPTH;
                else
                begin
                    w = stk_frames[stk_level - int'(rq.depth)];
                    rd = 1'b1;
                end
            end
            MODE_UNWIND:
            begin
                i = stk_level;
                while (i > 0 && !hit)
                begin
                    if ((stk_frames[i-1] & TAG_MASK) == WORD_W'(rq.tag))
                        hit = 1'b1;
                    else
                        i--;
                end
                if (hit)
                    stk_level = i;
                else
                begin
                    stk_level = 0;
                    rs.status = STATUS_NOT_FOUND;
                end
            end
            default:
            begin
            end
        endcase
        if (rd)
        begin
            rs.word    = w;
            rs.payload = PAYLOAD_W'($signed(w) >>> TAG_BITS);
            rs.tag     = TAG_W'(w & TAG_MASK);
        end
        rs.level = LEVEL_W'(stk_level);
        return rs;
    endfunction

    function automatic stim_row_t row(logic [MODE_W-1:0] m, logic [WORD_W-1:0] w,
                                      logic [PAYLOAD_W-1:0] p, logic [TAG_W-1:0] t,
                                      logic [DEPTH_W-1:0] d, logic fixed,
                                      logic [WORD_W-1:0] ew, logic [PAYLOAD_W-1:0] ep,
                                      logic [TAG_W-1:0] et, logic [STATUS_W-1:0] es,
                                      logic [LEVEL_W-1:0] el);
        stim_row_t r;
        r.req   = {m, w, p, t, d};
        r.fixed = fixed;
        r.rsp   = {ew, ep, et, es, el};
        return r;
    endfunction

    task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        stack_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected result: word_out %h status %0d level %0d",
                       word_out, status, level);
                err_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("word_out", want.word, word_out);
                check_field("payload_out", WORD_W'(want.payload), WORD_W'(payload_out));
                check_field("tag_out", WORD_W'(want.tag), WORD_W'(tag_out));
                check_field("status", WORD_W'(want.status), WORD_W'(status));
                check_field("level", WORD_W'(want.level), WORD_W'(level));
            end
        end
    end

    // random idle between beats, with occasional back-to-back stretches
    task automatic pause();
        int n;
        if (quiet_left > 0)
        begin
            quiet_left--;
            n = 0;
        end
        else
        begin
            n = $urandom_range(0, 99);
            if (n < 2)
                quiet_left = $urandom_range(20, 60);
            n = (n < 45) ? 0 : (n < 90) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        end
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send(stack_req_t rq, logic fixed, stack_rsp_t fixed_rsp);
        stack_rsp_t p;
        start      <= 1'b1;
        mode       <= rq.mode;
        frame_word <= rq.word;
        payload    <= rq.payload;
        tag        <= rq.tag;
        peek_depth <= rq.depth;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = stack_predict(rq);
        pending_rsp.push_back(fixed ? fixed_rsp : p);
    endtask

    task automatic run_rows();
        foreach (stim_rows[k])
        begin
            pause();
            send(stim_rows[k].req, stim_rows[k].fixed, stim_rows[k].rsp);
        end
        stim_rows.delete();
    endtask

    initial
    begin
        stack_req_t rq;
        int         r;
        int         pick;
        int         idx;
        logic       grow;

        rst_n      <= 1'b0;
        start      <= 1'b0;
        mode       <= '0;
        frame_word <= '0;
        payload    <= '0;
        tag        <= '0;
        peek_depth <= '0;

        stim_rows.push_back(row(MODE_POP, '0, '0, '0, '0,
                                1'b1, '0, '0, '0, STATUS_UNDERFLOW, 11'd0));
        stim_rows.push_back(row(MODE_PEEK, '0, '0, '0, 11'd1,
                                1'b1, '0, '0, '0, STATUS_BAD_DEPTH, 11'd0));
        stim_rows.push_back(row(MODE_UNWIND, '0, '0, '0, '0,
                                1'b1, '0, '0, '0, STATUS_NOT_FOUND, 11'd0));
        stim_rows.push_back(row(MODE_RSVD_5, WORD_ONES, PAY_MAX, 8'hFF, 11'd1024,
                                1'b1, '0, '0, '0, STATUS_OK, 11'd0));
        stim_rows.push_back(row(MODE_PUSH_RAW, WORD_ONES, '0, '0, '0,
                                1'b1, '0, '0, '0, STATUS_OK, 11'd1));
        stim_rows.push_back(row(MODE_PUSH_RAW, '0, PAY_MAX, 8'hFF, '0,
                                1'b1, '0, '0, '0, STATUS_OK, 11'd2));
        stim_rows.push_back(row(MODE_PUSH_TAGGED, '0, PAY_MAX, 8'hFF, '0,
                                1'b1, '0, '0, '0, STATUS_OK, 11'd3));
        stim_rows.push_back(row(MODE_PUSH_TAGGED, WORD_ONES, PAY_MIN, 8'h00, '0,
                                1'b1, '0, '0, '0, STATUS_OK, 11'd4));
        stim_rows.push_back(row(MODE_PEEK, '0, '0, '0, 11'd0,
                                1'b1, '0, '0, '0, STATUS_BAD_DEPTH, 11'd4));
        stim_rows.push_back(row(MODE_PEEK, '0, '0, '0, 11'd5,
                                1'b1, '0, '0, '0, STATUS_BAD_DEPTH, 11'd4));
        stim_rows.push_back(row(MODE_PEEK, '0, '0, '0, 11'd1024,
                                1'b1, '0, '0, '0, STATUS_BAD_DEPTH, 11'd4));
        stim_rows.push_back(row(MODE_PEEK, '0, '0, '0, 11'd4,
                                1'b1, WORD_ONES, '1, 8'hFF, STATUS_OK, 11'd4));
        stim_rows.push_back(row(MODE_PEEK, '0, '0, '0, 11'd1, 1'b0, '0, '0, '0, '0, '0));
        stim_rows.push_back(row(MODE_PEEK, '0, '0, '0, 11'd2, 1'b0, '0, '0, '0, '0, '0));
        stim_rows.push_back(row(MODE_POP, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0, '0));
        stim_rows.push_back(row(MODE_RSVD_6, '0, '0, '0, '0,
                                1'b1, '0, '0, '0, STATUS_OK, 11'd3));
        stim_rows.push_back(row(MODE_PUSH_RAW, 64'h0123_4567_89AB_CDEF, '0, '0, '0,
                                1'b0, '0, '0, '0, '0, '0));
        stim_rows.push_back(row(MODE_PUSH_TAGGED, '0, '1, 8'h5A, '0,
                                1'b0, '0, '0, '0, '0, '0));
        // tag found below the top: two frames discarded
        stim_rows.push_back(row(MODE_UNWIND, '0, '0, 8'hFF, '0, 1'b0, '0, '0, '0, '0, '0));
        // tag found on the top: nothing discarded
        stim_rows.push_back(row(MODE_UNWIND, '0, '0, 8'hFF, '0, 1'b0, '0, '0, '0, '0, '0));
        stim_rows.push_back(row(MODE_POP, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0, '0));
        stim_rows.push_back(row(MODE_RSVD_7, '0, '0, '0, '0,
                                1'b1, '0, '0, '0, STATUS_OK, 11'd2));
        stim_rows.push_back(row(MODE_UNWIND, '0, '0, 8'h77, '0,
                                1'b1, '0, '0, '0, STATUS_NOT_FOUND, 11'd0));
        stim_rows.push_back(row(MODE_PUSH_TAGGED, '0, 56'h55_AAAA_5555_AAAA, 8'hAA, '0,
                                1'b0, '0, '0, '0, '0, '0));
        stim_rows.push_back(row(MODE_POP, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0, '0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_rows();

        // fill to the limit; bottom frame carries a tag used nowhere else
        while (stk_level < STACK_DEPTH)
        begin
            rq.mode    = $urandom_range(0, 1) ? MODE_PUSH_TAGGED : MODE_PUSH_RAW;
            rq.word    = {$urandom, $urandom};
            rq.payload = PAYLOAD_W'({$urandom, $urandom});
            rq.tag     = TAG_W'($urandom);
            rq.depth   = DEPTH_W'($urandom_range(0, STACK_DEPTH));
            if (stk_level == 0)
            begin
                rq.mode = MODE_PUSH_TAGGED;
                rq.tag  = BASE_TAG;
            end
            else
            begin
                if (rq.tag == BASE_TAG || rq.tag == MISS_TAG)
                    rq.tag ^= 8'h10;
                if (rq.word[TAG_W-1:0] == BASE_TAG || rq.word[TAG_W-1:0] == MISS_TAG)
                    rq.word[TAG_W-1:0] ^= 8'h10;
            end
            pause();
            send(rq, 1'b0, '0);
        end

        stim_rows.push_back(row(MODE_PUSH_RAW, WORD_ONES, '0, '0, '0,
                                1'b1, '0, '0, '0, STATUS_OVERFLOW, FULL_LEVEL));
        stim_rows.push_back(row(MODE_PUSH_TAGGED, '0, PAY_MIN, 8'h01, '0,
                                1'b1, '0, '0, '0, STATUS_OVERFLOW, FULL_LEVEL));
        stim_rows.push_back(row(MODE_PEEK, '0, '0, '0, DEPTH_W'(STACK_DEPTH),
                                1'b0, '0, '0, '0, '0, '0));
        stim_rows.push_back(row(MODE_UNWIND, '0, '0, BASE_TAG, '0,
                                1'b1, '0, '0, '0, STATUS_OK, 11'd1));
        stim_rows.push_back(row(MODE_UNWIND, '0, '0, MISS_TAG, '0,
                                1'b1, '0, '0, '0, STATUS_NOT_FOUND, 11'd0));
        run_rows();

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            grow = ((n / PHASE_LEN) % 2) == 0;
            r = $urandom_range(0, 99);
            if (r < (grow ? 30 : 15))
                rq.mode = MODE_PUSH_RAW;
            else if (r < (grow ? 60 : 30))
                rq.mode = MODE_PUSH_TAGGED;
            else if (r < (grow ? 70 : 65))
                rq.mode = MODE_POP;
            else if (r < 85)
                rq.mode = MODE_PEEK;
            else if (r < 96)
                rq.mode = MODE_UNWIND;
            else
                rq.mode = MODE_W'(MODE_RSVD_5 + $urandom_range(0, 2));

            rq.word    = {$urandom, $urandom};
            rq.payload = PAYLOAD_W'({$urandom, $urandom});
            pick = $urandom_range(0, 19);
            if (pick == 0)
                rq.payload = PAY_MAX;
            else if (pick == 1)
                rq.payload = PAY_MIN;
            rq.tag   = TAG_W'($urandom);
            rq.depth = DEPTH_W'($urandom_range(0, STACK_DEPTH));

            if (rq.mode == MODE_PEEK)
            begin
                pick = $urandom_range(0, 9);
                if (stk_level > 0 && pick < 7)
                    rq.depth = DEPTH_W'($urandom_range(1, stk_level));
                else if (pick < 8)
                    rq.depth = '0;
                else if (pick < 9 && stk_level < STACK_DEPTH)
                    rq.depth = DEPTH_W'(stk_level + 1);
            end

            // mostly seek a tag that sits near the top
            if (rq.mode == MODE_UNWIND && stk_level > 0 && $urandom_range(0, 9) < 8)
            begin
                idx = stk_level - 1 - $urandom_range(0, (stk_level > 8) ? 7 : stk_level - 1);
                rq.tag = TAG_W'(stk_frames[idx] & TAG_MASK);
            end

            pause();
            send(rq, 1'b0, '0);
        end

        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_count == 0 && pending_rsp.size() == 0)
            $display("PASS tagged_frame_stack");
        else
            $display("FAIL tagged_frame_stack");
        $finish;
    end

endmodule

`default_nettype wire
